>>> src/rrdc_pkg.sv
// ----------------------------------------------------------------------------
// rrdc_pkg
// Shared types, widths, register indexes and multiplier operation codes for
// the rational resampler with DC-blocking output filter.
// ----------------------------------------------------------------------------
package rrdc_pkg;

    // Field widths
    localparam int ELAPSED_W = 6;
    localparam int LEVEL_W   = 16;
    localparam int CFG_W     = 21;
    localparam int CHARGE_W  = 16;
    localparam int ACC_W     = 28;
    localparam int CAP_W     = 33;
    localparam int DIFF_W    = 34;
    localparam int CFG_IDX_W = 2;

    // Burst limit and the counter that tracks it
    localparam int BURST_MAX = 64;
    localparam int CNT_W     = $clog2(BURST_MAX + 1);

    // Default output saturation width
    localparam int SAMPLE_BITS_DEF = 16;

    // Shared multiplier operand widths
    localparam int MUL_A_W  = 22;
    localparam int MUL_B_W  = 17;
    localparam int MUL_P_W  = MUL_A_W + MUL_B_W;
    // Low slice of the filter difference fed to the multiplier
    localparam int DLO_W    = 17;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CYCLES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE  = 2'd2;

    // Register reset values
    localparam logic [CFG_W-1:0]    CYCLES_RST  = 21'd65536;
    localparam logic [CFG_W-1:0]    SAMPLES_RST = 21'd3000;
    localparam logic [CHARGE_W-1:0] CHARGE_RST  = 16'd65300;

    // Multiplier operation codes
    localparam logic [1:0] MUL_PHASE = 2'd0;
    localparam logic [1:0] MUL_LO    = 2'd1;
    localparam logic [1:0] MUL_HI    = 2'd2;

    typedef logic        [ELAPSED_W-1:0] t_elapsed;
    typedef logic signed [LEVEL_W-1:0]   t_level;
    typedef logic        [CFG_W-1:0]     t_cfg_data;
    typedef logic        [CFG_IDX_W-1:0] t_cfg_idx;
    typedef logic        [CHARGE_W-1:0]  t_charge;
    typedef logic signed [DIFF_W-1:0]    t_diff;
    typedef logic signed [MUL_P_W-1:0]   t_prod;

endpackage

>>> src/rrdc_in_if.sv
// ----------------------------------------------------------------------------
// rrdc_in_if
// Input channel: elapsed machine cycles and the current stereo level.
// ----------------------------------------------------------------------------
interface rrdc_in_if;
    logic              valid;
    logic              ready;
    rrdc_pkg::t_elapsed elapsed_cycles;
    rrdc_pkg::t_level   level_left;
    rrdc_pkg::t_level   level_right;

    modport source (output valid, elapsed_cycles, level_left, level_right, input ready);
    modport sink   (input valid, elapsed_cycles, level_left, level_right, output ready);
endinterface

>>> src/rrdc_out_if.sv
// ----------------------------------------------------------------------------
// rrdc_out_if
// Output channel: one DC-blocked stereo sample per beat.
// ----------------------------------------------------------------------------
interface rrdc_out_if;
    logic             valid;
    logic             ready;
    rrdc_pkg::t_level out_left;
    rrdc_pkg::t_level out_right;
    logic             last_of_burst;

    modport source (output valid, out_left, out_right, last_of_burst, input ready);
    modport sink   (input valid, out_left, out_right, last_of_burst, output ready);
endinterface

>>> src/rrdc_mul.sv
// ----------------------------------------------------------------------------
// rrdc_mul
// Shared signed multiplier with operand selection and a registered product.
// ----------------------------------------------------------------------------
module rrdc_mul (
    input  logic                  i_clk,
    input  logic [1:0]            i_op,
    input  rrdc_pkg::t_cfg_data   i_samples,
    input  rrdc_pkg::t_elapsed    i_elapsed,
    input  rrdc_pkg::t_diff       i_diff,
    input  rrdc_pkg::t_charge     i_charge,
    output rrdc_pkg::t_prod       o_prod
);
    import rrdc_pkg::*;

    logic signed [MUL_A_W-1:0] w_a;
    logic signed [MUL_B_W-1:0] w_b;
    t_prod                     r_prod;

    always_comb begin
        unique case (i_op)
            MUL_PHASE: begin
                w_a = MUL_A_W'({1'b0, i_samples});
                w_b = MUL_B_W'({1'b0, i_elapsed});
            end
            MUL_LO: begin
                w_a = MUL_A_W'({1'b0, i_diff[DLO_W-1:0]});
                w_b = MUL_B_W'({1'b0, i_charge});
            end
            MUL_HI: begin
                // Upper slice keeps the sign of the difference.
                w_a = MUL_A_W'($signed(i_diff[DIFF_W-1:DLO_W]));
                w_b = MUL_B_W'({1'b0, i_charge});
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= MUL_P_W'(w_a) * MUL_P_W'(w_b);
    end

    assign o_prod = r_prod;

endmodule

>>> src/rational_resampler_dc_blocker.sv
// ----------------------------------------------------------------------------
// rational_resampler_dc_blocker
// Phase-accumulator rate converter with a one-pole DC blocker per channel.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake         Payload
//  i_in      in   valid / ready     elapsed_cycles, level_left, level_right
//  o_out     out  valid / ready     out_left, out_right, last_of_burst
//  i_cfg_*   in   write enable      index (2 bits), data (21 bits)
//
//  An item emits n samples, n being at most 64, and an output stall holds it;
//  with REG_CYCLES at zero it returns to idle after the accumulator update.
//  The phase product is registered in the multiplier before that update.
//  Each sample passes the DIFF, MLO, MHI, SUM and CAP states per channel on
//  the one shared multiplier and a compare step, then one beat on o_out.
//  Reset loads the register defaults and clears the accumulator and capacitors.
//  i_in.ready is high only while the block is idle; an output stall holds it.
// ----------------------------------------------------------------------------
module rational_resampler_dc_blocker #(
    parameter int SAMPLE_BITS = rrdc_pkg::SAMPLE_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  rrdc_pkg::t_cfg_idx  i_cfg_index,
    input  rrdc_pkg::t_cfg_data i_cfg_data,
    rrdc_in_if.sink             i_in,
    rrdc_out_if.source          o_out
);
    import rrdc_pkg::*;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_ACC  = 4'd1;
    localparam logic [3:0] S_CHK  = 4'd2;
    localparam logic [3:0] S_DIFF = 4'd3;
    localparam logic [3:0] S_MLO  = 4'd4;
    localparam logic [3:0] S_MHI  = 4'd5;
    localparam logic [3:0] S_SUM  = 4'd6;
    localparam logic [3:0] S_CAP  = 4'd7;
    localparam logic [3:0] S_EMIT = 4'd8;
    localparam logic [3:0] S_MPH  = 4'd9;

    localparam int SAT_W = SAMPLE_BITS + 20;
    localparam logic signed [SAT_W-1:0] SAT_HI = SAT_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [SAT_W-1:0] SAT_LO = -SAT_HI - SAT_W'(1);

    localparam int SUM_W = 51;
    localparam int NC_W  = 36;
    localparam logic signed [NC_W-1:0] CAP_HI = NC_W'((64'sd1 <<< (CAP_W - 1)) - 1);
    localparam logic signed [NC_W-1:0] CAP_LO = -CAP_HI - NC_W'(1);
    localparam logic [ACC_W-1:0] ACC_MAX = '1;

    logic [3:0]               r_state;
    t_cfg_data                r_cycles;
    t_cfg_data                r_samples;
    t_charge                  r_charge;
    logic [ACC_W-1:0]         r_acc;
    logic signed [CAP_W-1:0]  r_cap_l;
    logic signed [CAP_W-1:0]  r_cap_r;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_ch;
    t_elapsed                 r_elapsed;
    t_level                   r_lvl_l;
    t_level                   r_lvl_r;
    t_diff                    r_d;
    t_prod                    r_plo;
    logic signed [SUM_W-1:0]  r_sum;
    t_level                   r_out_l;
    t_level                   r_out_r;
    logic                     r_last;

    logic [1:0]               w_mul_op;
    t_prod                    w_prod;
    t_level                   w_level;
    logic signed [31:0]       w_in_q;
    logic signed [CAP_W-1:0]  w_cap;
    logic [ACC_W:0]           w_acc_sum;
    logic signed [DIFF_W:0]   w_rnd;
    logic signed [SAT_W-1:0]  w_s;
    t_level                   w_samp;
    logic signed [NC_W-1:0]   w_nc;
    logic signed [CAP_W-1:0]  w_nc_sat;
    logic                     w_cfg_hit;
    logic                     w_more;

    always_comb begin
        unique case (r_state)
            S_MLO:   w_mul_op = MUL_LO;
            S_MHI:   w_mul_op = MUL_HI;
            default: w_mul_op = MUL_PHASE;
        endcase
    end

    rrdc_mul u_mul (
        .i_clk     (i_clk),
        .i_op      (w_mul_op),
        .i_samples (r_samples),
        .i_elapsed (r_elapsed),
        .i_diff    (r_d),
        .i_charge  (r_charge),
        .o_prod    (w_prod)
    );

    assign w_level   = r_ch ? r_lvl_r : r_lvl_l;
    assign w_cap     = r_ch ? r_cap_r : r_cap_l;
    assign w_in_q    = {w_level, 16'h0000};
    assign w_acc_sum = (ACC_W+1)'(r_acc) + (ACC_W+1)'(w_prod[ACC_W-2:0]);

    // Sample: round half up, then clip to the configured sample width.
    assign w_rnd = (DIFF_W+1)'(r_d) + (DIFF_W+1)'(32768);
    assign w_s   = SAT_W'($signed(w_rnd[DIFF_W:16]));
    always_comb begin
        priority if (w_s > SAT_HI) begin
            w_samp = SAT_HI[LEVEL_W-1:0];
        end else if (w_s < SAT_LO) begin
            w_samp = SAT_LO[LEVEL_W-1:0];
        end else begin
            w_samp = w_s[LEVEL_W-1:0];
        end
    end

    // New capacitor from the rounded product of difference and charge.
    assign w_nc = NC_W'(w_in_q) - NC_W'($signed(r_sum[SUM_W-1:16]));
    always_comb begin
        priority if (w_nc > CAP_HI) begin
            w_nc_sat = CAP_HI[CAP_W-1:0];
        end else if (w_nc < CAP_LO) begin
            w_nc_sat = CAP_LO[CAP_W-1:0];
        end else begin
            w_nc_sat = w_nc[CAP_W-1:0];
        end
    end

    assign w_cfg_hit = i_cfg_we && (i_cfg_index == REG_CYCLES ||
                                    i_cfg_index == REG_SAMPLES ||
                                    i_cfg_index == REG_CHARGE);
    assign w_more    = (r_cnt < CNT_W'(BURST_MAX)) && (r_acc >= ACC_W'(r_cycles));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cycles  <= CYCLES_RST;
            r_samples <= SAMPLES_RST;
            r_charge  <= CHARGE_RST;
            r_acc     <= '0;
            r_cap_l   <= '0;
            r_cap_r   <= '0;
            r_cnt     <= '0;
            r_ch      <= 1'b0;
            r_last    <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_state <= S_MPH;
                    end
                end
                // The multiplier forms the phase step from the captured item.
                S_MPH: r_state <= S_ACC;
                S_ACC: begin
                    r_acc <= w_acc_sum[ACC_W] ? ACC_MAX : w_acc_sum[ACC_W-1:0];
                    r_cnt <= '0;
                    r_state <= (r_cycles == '0) ? S_IDLE : S_CHK;
                end
                S_CHK: begin
                    if (w_more) begin
                        r_acc   <= r_acc - ACC_W'(r_cycles);
                        r_ch    <= 1'b0;
                        r_state <= S_DIFF;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_DIFF: r_state <= S_MLO;
                S_MLO:  r_state <= S_MHI;
                S_MHI:  r_state <= S_SUM;
                S_SUM:  r_state <= S_CAP;
                S_CAP: begin
                    if (r_ch) begin
                        r_cap_r <= w_nc_sat;
                        // The next sample of this burst would be past the limit
                        // or lack the phase for it.
                        r_last  <= (r_cnt == CNT_W'(BURST_MAX - 1)) ||
                                   (r_acc < ACC_W'(r_cycles));
                        r_state <= S_EMIT;
                    end else begin
                        r_cap_l <= w_nc_sat;
                        r_ch    <= 1'b1;
                        r_state <= S_DIFF;
                    end
                end
                S_EMIT: begin
                    if (o_out.ready) begin
                        r_cnt   <= r_cnt + CNT_W'(1);
                        r_state <= S_CHK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (w_cfg_hit) begin
                unique case (i_cfg_index)
                    REG_CYCLES:  r_cycles  <= i_cfg_data;
                    REG_SAMPLES: r_samples <= i_cfg_data;
                    default:     r_charge  <= i_cfg_data[CHARGE_W-1:0];
                endcase
                r_acc   <= '0;
                r_cap_l <= '0;
                r_cap_r <= '0;
            end
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in.valid) begin
            r_elapsed <= i_in.elapsed_cycles;
            r_lvl_l   <= i_in.level_left;
            r_lvl_r   <= i_in.level_right;
        end
        if (r_state == S_DIFF) begin
            r_d <= DIFF_W'(w_in_q) - DIFF_W'(w_cap);
        end
        if (r_state == S_MLO) begin
            if (r_ch) begin
                r_out_r <= w_samp;
            end else begin
                r_out_l <= w_samp;
            end
        end
        if (r_state == S_MHI) begin
            r_plo <= w_prod;
        end
        if (r_state == S_SUM) begin
            r_sum <= (SUM_W'(w_prod) <<< DLO_W) + SUM_W'(r_plo) + SUM_W'(32768);
        end
    end

    assign i_in.ready          = (r_state == S_IDLE);
    assign o_out.valid         = (r_state == S_EMIT);
    assign o_out.out_left      = r_out_l;
    assign o_out.out_right     = r_out_r;
    assign o_out.last_of_burst = r_last;

    // A taken item blocks the input until its burst is finished.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> !i_in.ready)
        else $error("input accepted while an item is in progress");

    // The final beat of a burst returns the block to idle.
    a_last_ends_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && o_out.last_of_burst |-> ##2 (r_state == S_IDLE))
        else $error("burst continued after its final beat");

    // A beat that is not final is followed by another sample.
    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.ready && !o_out.last_of_burst |-> ##2 (r_state == S_DIFF))
        else $error("burst ended without a final beat");

    // The burst counter never passes the limit.
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BURST_MAX))
        else $error("burst counter overflow");

endmodule

>>> tb/tb_rational_resampler_dc_blocker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_resampler_dc_blocker
// Self-checking bench for the rational resampler with DC blocker. It sends
// level items, predicts every stereo sample in step with each accepted input
// beat, and compares each output beat with the oldest prediction. The run
// steps through several register settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_rational_resampler_dc_blocker;
    import rrdc_pkg::*;

    localparam int        SAMPLE_BITS  = SAMPLE_BITS_DEF;
    localparam t_cfg_idx  REG_SPARE    = 2'd3;
    localparam longint    ACC_LIMIT    = (64'sd1 <<< ACC_W) - 1;
    localparam longint    CAP_HI       = (64'sd1 <<< (CAP_W - 1)) - 1;
    localparam longint    CAP_LO       = -(64'sd1 <<< (CAP_W - 1));
    localparam longint    OUT_HI       = (64'sd1 <<< (SAMPLE_BITS - 1)) - 1;
    localparam longint    OUT_LO       = -OUT_HI - 1;
    localparam t_cfg_data CFG_ALL      = '1;
    localparam t_level    LEVEL_MAX    = 16'sh7FFF;
    localparam t_level    LEVEL_MIN    = 16'sh8000;
    localparam int        CYCLE_LIMIT  = 3_000_000;
    localparam int        DRAIN_CYCLES = 40;

    typedef struct packed {
        t_elapsed elapsed;
        t_level   left;
        t_level   right;
    } t_level_item;

    typedef struct packed {
        t_level left;
        t_level right;
        logic   last;
    } t_stereo_sample;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_cfg_we;
    t_cfg_idx  i_cfg_index;
    t_cfg_data i_cfg_data;

    rrdc_in_if  in_ch();
    rrdc_out_if out_ch();

    rational_resampler_dc_blocker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    // Predictor state and register copies
    longint phase_acc;
    longint cap_left;
    longint cap_right;
    longint cycles_cfg;
    longint samples_cfg;
    longint charge_cfg;

    t_level_item    level_items[$];
    t_stereo_sample expected_samples[$];

    int   mismatches  = 0;
    int   idle_pct    = 0;
    int   cycle_count = 0;
    int   send_gap    = 0;
    int   stall_left  = 0;
    logic in_beat     = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // One channel of the DC blocker; updates the capacitor in place.
    function automatic t_level dc_block(input t_level level, inout longint cap);
        longint in_q;
        longint diff;
        longint s;
        in_q = longint'(level) * 65536;
        diff = in_q - cap;
        s = (diff + 32768) >>> 16;
        if (s > OUT_HI) s = OUT_HI;
        if (s < OUT_LO) s = OUT_LO;
        cap = in_q - ((diff * charge_cfg + 32768) >>> 16);
        if (cap > CAP_HI) cap = CAP_HI;
        if (cap < CAP_LO) cap = CAP_LO;
        return s[LEVEL_W-1:0];
    endfunction

    task automatic resample_item(input t_level_item item);
        t_stereo_sample smp;
        int count;
        count = 0;
        phase_acc += longint'(item.elapsed) * samples_cfg;
        if (phase_acc > ACC_LIMIT) phase_acc = ACC_LIMIT;
        if (cycles_cfg != 0) begin
            while (count < BURST_MAX && phase_acc >= cycles_cfg) begin
                phase_acc -= cycles_cfg;
                smp.left  = dc_block(item.left, cap_left);
                smp.right = dc_block(item.right, cap_right);
                count++;
                smp.last  = (count == BURST_MAX) || (phase_acc < cycles_cfg);
                expected_samples = {expected_samples, smp};
            end
        end
    endtask

    task automatic check_sample();
        t_stereo_sample want;
        if (expected_samples.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected sample: L %0d R %0d last %0b",
                         out_ch.out_left, out_ch.out_right, out_ch.last_of_burst);
        end else begin
            want = expected_samples.pop_front();
            if (want.left !== out_ch.out_left || want.right !== out_ch.out_right ||
                want.last !== out_ch.last_of_burst) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp L %0d R %0d last %0b, got L %0d R %0d last %0b",
                             want.left, want.right, want.last,
                             out_ch.out_left, out_ch.out_right, out_ch.last_of_burst);
            end
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_level_item taken;
        cycle_count <= cycle_count + 1;
        in_beat <= in_ch.valid && in_ch.ready;
        if (i_rst_n && in_ch.valid && in_ch.ready) begin
            taken.elapsed = in_ch.elapsed_cycles;
            taken.left    = in_ch.level_left;
            taken.right   = in_ch.level_right;
            resample_item(taken);
        end
        if (i_rst_n && out_ch.valid && out_ch.ready)
            check_sample();
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_rational_resampler_dc_blocker NOT OK");
            $finish;
        end
    end

    // Input beats and output stalls change on the falling edge.
    always @(negedge i_clk) begin : driver
        t_level_item queued;
        if (!i_rst_n) begin
            in_ch.valid  <= 1'b0;
            out_ch.ready <= 1'b0;
        end else begin
            if (!in_ch.valid || in_beat) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_ch.valid <= 1'b0;
                end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
                    send_gap = $urandom_range(0, 4);
                    in_ch.valid <= 1'b0;
                end else if (level_items.size() != 0) begin
                    queued = level_items.pop_front();
                    in_ch.valid          <= 1'b1;
                    in_ch.elapsed_cycles <= queued.elapsed;
                    in_ch.level_left     <= queued.left;
                    in_ch.level_right    <= queued.right;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_pct != 0 && $urandom_range(1, 100) <= idle_pct) begin
                stall_left = $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    task automatic reg_write(input t_cfg_idx idx, input t_cfg_data data);
        logic clears;
        clears = 1'b1;
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        case (idx)
            REG_CYCLES:  cycles_cfg  = data;
            REG_SAMPLES: samples_cfg = data;
            REG_CHARGE:  charge_cfg  = data[CHARGE_W-1:0];
            default:     clears = 1'b0;
        endcase
        if (clears) begin
            phase_acc = 0;
            cap_left  = 0;
            cap_right = 0;
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic program_regs(input t_cfg_data cyc, input t_cfg_data smp,
                                input t_cfg_data chg);
        reg_write(REG_CYCLES, cyc);
        reg_write(REG_SAMPLES, smp);
        reg_write(REG_CHARGE, chg);
    endtask

    // Waits for every queued item and predicted sample, then lets an item
    // that emits nothing finish inside the block.
    task automatic wait_idle();
        while (level_items.size() != 0 || in_ch.valid || expected_samples.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic t_level rand_level();
        case ($urandom_range(0, 7))
            0:       return LEVEL_MIN;
            1:       return LEVEL_MAX;
            2:       return t_level'($urandom_range(0, 64)) - 16'sd32;
            default: return t_level'($urandom);
        endcase
    endfunction

    function automatic t_cfg_data pick_charge();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return t_cfg_data'(16'hFFFF);
            2:       return t_cfg_data'(CHARGE_RST);
            default: return t_cfg_data'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic add_item(input t_elapsed el, input t_level l, input t_level r);
        t_level_item item;
        item.elapsed = el;
        item.left    = l;
        item.right   = r;
        level_items = {level_items, item};
    endtask

    task automatic add_random(input int n);
        t_elapsed el;
        repeat (n) begin
            el = ($urandom_range(0, 9) == 0) ? t_elapsed'(0) : t_elapsed'($urandom_range(0, 63));
            add_item(el, rand_level(), rand_level());
        end
    endtask

    initial begin
        int rate;
        i_rst_n            = 1'b0;
        i_cfg_we           = 1'b0;
        i_cfg_index        = REG_CYCLES;
        i_cfg_data         = '0;
        in_ch.valid        = 1'b0;
        in_ch.elapsed_cycles = '0;
        in_ch.level_left   = '0;
        in_ch.level_right  = '0;
        out_ch.ready       = 1'b0;
        cycles_cfg  = CYCLES_RST;
        samples_cfg = SAMPLES_RST;
        charge_cfg  = CHARGE_RST;
        phase_acc   = 0;
        cap_left    = 0;
        cap_right   = 0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset defaults: field extremes, zero elapsed time, full-scale swings.
        idle_pct = 25;
        add_item(6'd0, 16'sd0, 16'sd0);
        add_item(6'd63, LEVEL_MAX, LEVEL_MIN);
        add_item(6'd63, LEVEL_MIN, LEVEL_MAX);
        add_item(6'd63, LEVEL_MIN, LEVEL_MAX);
        add_item(6'd0, 16'sd100, -16'sd100);
        add_item(6'd1, 16'sd0, -16'sd1);
        add_item(6'd42, 16'sh5555, 16'shAAAA);
        add_item(6'd21, 16'shAAAA, 16'sh5555);
        add_item(6'd63, LEVEL_MAX, LEVEL_MAX);
        add_item(6'd63, -16'sd1, 16'sd0);
        add_random(60);
        wait_idle();

        // One sample per elapsed cycle, no capacitor retention.
        idle_pct = 40;
        program_regs(21'd1, 21'd1, '0);
        add_random(35);
        wait_idle();

        // All-ones registers and full retention.
        idle_pct = 10;
        program_regs(CFG_ALL, CFG_ALL, t_cfg_data'(16'hFFFF));
        add_random(35);
        wait_idle();

        // A write to the spare index must leave the filter state alone.
        reg_write(REG_SPARE, t_cfg_data'($urandom));
        add_random(10);
        wait_idle();

        // Fast phase: bursts hit the limit and the accumulator saturates,
        // then zero-elapsed items drain what is left.
        idle_pct = 25;
        program_regs(t_cfg_data'(1 << 20), CFG_ALL, pick_charge());
        repeat (4) add_item(6'd63, rand_level(), rand_level());
        repeat (6) add_item(6'd0, rand_level(), rand_level());
        wait_idle();

        // Zero cycles register: nothing comes out.
        program_regs('0, t_cfg_data'($urandom_range(1, 2097151)), pick_charge());
        add_random(15);
        wait_idle();

        for (int ph = 0; ph < 3; ph++) begin
            rate = $urandom_range(1, 4000);
            program_regs(t_cfg_data'(rate * $urandom_range(1, 50)), t_cfg_data'(rate),
                         pick_charge());
            idle_pct = (ph == 0) ? 15 : (ph == 1) ? 50 : 0;
            add_random(45);
            wait_idle();
        end

        if (mismatches == 0 && expected_samples.size() == 0) begin
            $display("tb_rational_resampler_dc_blocker OK");
        end else begin
            $display("tb_rational_resampler_dc_blocker NOT OK");
        end
        $finish;
    end

endmodule

>>> rational_resampler_dc_blocker.f
src/rrdc_pkg.sv
src/rrdc_in_if.sv
src/rrdc_out_if.sv
src/rrdc_mul.sv
src/rational_resampler_dc_blocker.sv
tb/tb_rational_resampler_dc_blocker.sv
